FILE: rtl/ifx_pkg.sv
// Package for the infix evaluator: character codes, status codes, term ops, states.
// No dependencies.
package ifx_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_BAD  = 3'd1;
  localparam logic [2:0] ST_POS  = 3'd2;
  localparam logic [2:0] ST_TWO  = 3'd3;
  localparam logic [2:0] ST_DIV0 = 3'd4;
  localparam logic [2:0] ST_OVF  = 3'd5;

  typedef enum logic [1:0] {
    TOP_NONE = 2'd0,
    TOP_MUL  = 2'd1,
    TOP_DIV  = 2'd2
  } term_op_t;

  // Class of a character after the front end has decoded it.
  typedef enum logic [2:0] {
    CL_DIGIT = 3'd0,
    CL_PLUS  = 3'd1,
    CL_MINUS = 3'd2,
    CL_MUL   = 3'd3,
    CL_DIV   = 3'd4,
    CL_SPACE = 3'd5,
    CL_BAD   = 3'd6
  } char_class_t;

  // One classified beat handed from front to back.
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_MUL,
    S_DIV,
    S_FOLD,
    S_OUT
  } bstate_t;

endpackage

FILE: rtl/ifx_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload width is a parameter.
interface ifx_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ifx_front.sv
// Front end: classifies characters and pushes them into a two-entry queue.
// Depends on ifx_pkg.
module ifx_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  output logic        q_valid,
  input  logic        q_pop,
  output ifx_pkg::tok_t q_tok
);
  import ifx_pkg::*;

  tok_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  tok_t       tok;
  logic       push;

  // Decode the character class.
  always_comb begin
    tok.last  = in_last;
    tok.digit = 4'(in_char - CH_ZERO);
    if (in_char >= CH_ZERO && in_char <= CH_NINE) tok.cls = CL_DIGIT;
    else if (in_char == CH_PLUS) tok.cls = CL_PLUS;
    else if (in_char == CH_MINUS) tok.cls = CL_MINUS;
    else if (in_char == CH_MUL) tok.cls = CL_MUL;
    else if (in_char == CH_DIV) tok.cls = CL_DIV;
    else if (in_char == CH_SPACE) tok.cls = CL_SPACE;
    else tok.cls = CL_BAD;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_tok    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= tok;
  end
endmodule

FILE: rtl/ifx_back.sv
// Back end: executes classified beats on the sum, term and literal state.
// Depends on ifx_pkg; holds a two-step multiplier and a restoring divider for terms.
module ifx_back #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  ifx_pkg::tok_t          q_tok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [2:0]             out_status
);
  import ifx_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int MW = W + 32;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [63:0]  ILIM = 64'(VMAX) >> FRAC_BITS;

  bstate_t       st_r, st_nxt;
  logic [W-1:0]  sum_r, term_r;
  logic [31:0]   acc_r, lit_r;
  term_op_t      op_r;
  logic          sign_r, lwo_r, seen_r, open_r;
  logic [2:0]    err_r;
  tok_t          tok_r;
  logic          mph_r;
  logic [MW-1:0] macc_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [W-1:0]  val_r;
  logic [2:0]    sts_r;

  logic          tok_is_op;
  logic [35:0]   acc_ext;
  logic          acc_sat;
  logic          seen_n, lwo_n;
  logic [2:0]    err_in;
  logic          lit_ovf;
  logic [31:0]   lit_c;
  logic [2:0]    err_cl;
  logic [15:0]   mslice;
  logic [W+15:0] mprod;
  logic [MW-1:0] macc_nxt;
  logic [33:0]   trial;
  logic [W:0]    fsum;
  logic          fov;
  logic [W-1:0]  fsat;
  logic [2:0]    err_fold;

  // Merge a new error into the held code by priority.
  function automatic logic [2:0] merge(input logic [2:0] e, input logic [2:0] c);
    logic [2:0] r;
    r = e;
    if (c == ST_BAD) r = ST_BAD;
    else if (c == ST_POS) begin
      if (e != ST_BAD) r = ST_POS;
    end else if (e == ST_OK) r = c;
    return r;
  endfunction

  // Decode of the head beat of the queue: literal growth, overflow and syntax errors.
  always_comb begin
    tok_is_op = (q_tok.cls == CL_PLUS) || (q_tok.cls == CL_MINUS) ||
                (q_tok.cls == CL_MUL) || (q_tok.cls == CL_DIV);
    acc_ext = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 36'(q_tok.digit);
    acc_sat = (acc_ext[35:32] != 4'd0);
    err_in = err_r;
    if (q_tok.cls == CL_BAD) err_in = merge(err_in, ST_BAD);
    else if (q_tok.cls == CL_DIGIT) begin
      if (acc_sat) err_in = merge(err_in, ST_OVF);
    end else if (tok_is_op) begin
      if (!seen_r) err_in = merge(err_in, ST_POS);
      else if (lwo_r) err_in = merge(err_in, ST_TWO);
    end
    seen_n = seen_r || (q_tok.cls == CL_DIGIT);
    lwo_n  = (q_tok.cls == CL_DIGIT) ? 1'b0 : (tok_is_op ? 1'b1 : lwo_r);
    if (q_tok.last && (!seen_n || lwo_n)) err_in = merge(err_in, ST_POS);
  end

  // Literal clamp, multiplier step, divider step and saturating fold.
  always_comb begin
    lit_ovf  = ({32'd0, acc_r} > ILIM);
    lit_c    = lit_ovf ? ILIM[31:0] : acc_r;
    err_cl   = lit_ovf ? merge(err_r, ST_OVF) : err_r;
    mslice   = mph_r ? lit_r[15:0] : lit_r[31:16];
    mprod    = term_r * mslice;
    macc_nxt = {macc_r[MW-17:0], 16'd0} + {16'd0, mprod};
    trial    = {1'b0, rem_r, term_r[W-1]} - {2'b00, lit_r};
    if (sign_r) fsum = {sum_r[W-1], sum_r} - {1'b0, term_r};
    else fsum = {sum_r[W-1], sum_r} + {1'b0, term_r};
    fov      = fsum[W] != fsum[W-1];
    fsat     = fov ? (sign_r ? VMIN : VMAX) : fsum[W-1:0];
    err_fold = fov ? merge(err_r, ST_OVF) : err_r;
  end

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid && (q_tok.last || tok_is_op)) st_nxt = S_CLOSE;
      S_CLOSE: begin
        if (!open_r) st_nxt = S_FOLD;
        else if (op_r == TOP_MUL) st_nxt = S_MUL;
        else if (op_r == TOP_DIV && lit_c != 32'd0) st_nxt = S_DIV;
        else st_nxt = S_FOLD;
      end
      S_MUL:   if (mph_r) st_nxt = S_FOLD;
      S_DIV:   if (cnt_r == CW'(1)) st_nxt = S_FOLD;
      S_FOLD:  st_nxt = tok_r.last ? S_OUT : S_IDLE;
      S_OUT:   if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    q_pop      = (st_r == S_IDLE) && q_valid;
    out_valid  = (st_r == S_OUT);
    out_value  = val_r;
    out_status = sts_r;
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sum_r <= '0; term_r <= '0; acc_r <= '0; lit_r <= '0; op_r <= TOP_NONE;
      sign_r <= 1'b0; lwo_r <= 1'b0; seen_r <= 1'b0; open_r <= 1'b0;
      err_r <= ST_OK; tok_r <= '0; mph_r <= 1'b0; macc_r <= '0;
      cnt_r <= '0; rem_r <= '0; val_r <= '0; sts_r <= ST_OK;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          tok_r <= q_tok;
          // Digits grow the literal; operators only mark their position here.
          if (q_tok.cls == CL_DIGIT) begin
            acc_r  <= acc_sat ? 32'hFFFF_FFFF : acc_ext[31:0];
            open_r <= 1'b1; seen_r <= 1'b1; lwo_r <= 1'b0;
          end else if (tok_is_op) lwo_r <= 1'b1;
          err_r <= err_in;
        end
        S_CLOSE: if (open_r) begin
          // Clamp the literal and start the pending term operation.
          lit_r <= lit_c;
          if (op_r == TOP_MUL) begin
            mph_r <= 1'b0; macc_r <= '0; err_r <= err_cl;
          end else if (op_r == TOP_DIV && lit_c != 32'd0) begin
            rem_r <= '0; cnt_r <= CW'(W); err_r <= err_cl;
          end else begin
            if (op_r == TOP_DIV) begin
              term_r <= VMAX;
              err_r  <= merge(err_cl, ST_DIV0);
            end else begin
              term_r <= W'(lit_c) << FRAC_BITS;
              err_r  <= err_cl;
            end
            op_r <= TOP_NONE; acc_r <= '0; open_r <= 1'b0;
          end
        end
        S_MUL: begin
          // Sixteen literal bits per cycle, high half first.
          mph_r  <= 1'b1;
          macc_r <= macc_nxt;
          if (mph_r) begin
            if (macc_nxt > MW'(VMAX)) begin
              term_r <= VMAX;
              err_r  <= merge(err_r, ST_OVF);
            end else term_r <= macc_nxt[W-1:0];
            op_r <= TOP_NONE; acc_r <= '0; open_r <= 1'b0;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle, shifted into the term register.
          term_r <= {term_r[W-2:0], ~trial[33]};
          rem_r  <= trial[33] ? {rem_r[30:0], term_r[W-1]} : trial[31:0];
          cnt_r  <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            op_r <= TOP_NONE; acc_r <= '0; open_r <= 1'b0;
          end
        end
        S_FOLD: begin
          // The last beat builds the result and clears the state.
          if (tok_r.last) begin
            sts_r <= err_fold;
            val_r <= (err_fold == ST_BAD || err_fold == ST_POS || err_fold == ST_TWO) ?
                     '0 : fsat;
            sum_r <= '0; term_r <= '0; acc_r <= '0; op_r <= TOP_NONE;
            sign_r <= 1'b0; lwo_r <= 1'b0; seen_r <= 1'b0; open_r <= 1'b0;
            err_r <= ST_OK;
          end else if (tok_r.cls == CL_PLUS || tok_r.cls == CL_MINUS) begin
            sum_r  <= fsat;
            term_r <= '0;
            err_r  <= err_fold;
            op_r   <= TOP_NONE;
            sign_r <= (tok_r.cls == CL_MINUS);
          end else if (tok_r.cls == CL_MUL) op_r <= TOP_MUL;
          else if (tok_r.cls == CL_DIV) op_r <= TOP_DIV;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/infix_four_op_evaluator.sv
// Infix evaluator, one character per beat; result in signed fixed point with
// FRAC_BITS fraction bits. A beat waits in the queue, then a digit, space or
// bad character takes only the decode state of the back end. An operator or the
// last beat passes decode, close literal and fold, plus the multiply steps when a
// multiply is pending and the divider steps when a divide is pending. The result
// is held until accepted; meanwhile the two-beat queue fills and then the input
// stalls.
// Top level: ties ifx_front and ifx_back to the channel interfaces.
// Depends on ifx_pkg, ifx_if, ifx_front, ifx_back.
module infix_four_op_evaluator #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  ifx_if.sink   in_ch,
  ifx_if.source out_ch
);
  import ifx_pkg::*;

  logic q_valid, q_pop;
  tok_t q_tok;
  logic [VALUE_WIDTH-1:0] value;
  logic [2:0] status;

  ifx_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_char(in_ch.data[7:0]), .in_last(in_ch.data[8]),
    .q_valid, .q_pop, .q_tok
  );

  ifx_back #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_tok,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(value), .out_status(status)
  );

  assign out_ch.data = {status, value};
endmodule

FILE: tb/infix_four_op_evaluator_test.sv
// Self-checking testbench for infix_four_op_evaluator: characters in, value and status out.
// It computes each expected result on its own and compares every output beat in order.
// Depends on ifx_pkg, ifx_if and the evaluator RTL.
module infix_four_op_evaluator_test;
  import ifx_pkg::*;

  localparam int VW = 48;
  localparam int FB = 16;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam logic [63:0] INT_LIM = 64'(VMAX) >> FB;
  localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;
  localparam int LIMIT = 2000000;

  typedef struct {
    bit          hold_for_drain;
    logic [7:0]  ch;
    logic        last;
  } char_beat_t;

  typedef struct {
    logic [VW-1:0] value;
    logic [2:0]    status;
  } answer_t;

  logic clk;
  logic rst_n;
  ifx_if #(9)      in_ch ();
  ifx_if #(VW + 3) out_ch ();

  infix_four_op_evaluator #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  char_beat_t char_q[$];
  answer_t    answer_q[$];
  int         errors;
  int         cycles;
  bit         in_took;
  int         send_gap;
  int         recv_gap;
  int         recv_hold;
  bit         stim_done;

  // Evaluator state kept by the predictor.
  longint     sum_r;
  logic [63:0] term_r;
  logic [31:0] acc_r;
  term_op_t   top_r;
  bit         minus_r;
  bit         after_op_r;
  bit         have_digit_r;
  bit         open_r;
  logic [2:0] err_r;

  // Clock and one reset at the start.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic void clear_eval();
    sum_r = 0;
    term_r = '0;
    acc_r = '0;
    top_r = TOP_NONE;
    minus_r = 1'b0;
    after_op_r = 1'b0;
    have_digit_r = 1'b0;
    open_r = 1'b0;
    err_r = ST_OK;
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (code == ST_BAD) begin
      err_r = ST_BAD;
    end else if (code == ST_POS) begin
      if (err_r != ST_BAD) err_r = ST_POS;
    end else if (err_r == ST_OK) begin
      err_r = code;
    end
  endfunction

  // Finish the open literal: load it as the term or apply the pending multiply or divide.
  function automatic void end_literal();
    logic [63:0] lit;
    lit = {32'd0, acc_r};
    if (!open_r) return;
    if (lit > INT_LIM) begin
      lit = INT_LIM;
      flag_error(ST_OVF);
    end
    if (top_r == TOP_MUL) begin
      if (lit != 0 && term_r > 64'(VMAX) / lit) begin
        flag_error(ST_OVF);
        term_r = 64'(VMAX);
      end else begin
        term_r = term_r * lit;
      end
    end else if (top_r == TOP_DIV) begin
      if (lit == 0) begin
        flag_error(ST_DIV0);
        term_r = 64'(VMAX);
      end else begin
        term_r = term_r / lit;
      end
    end else begin
      term_r = lit << FB;
    end
    top_r = TOP_NONE;
    acc_r = '0;
    open_r = 1'b0;
  endfunction

  // Add or subtract the term into the sum with saturation.
  function automatic void fold_into_sum();
    longint t;
    t = longint'(term_r);
    if (minus_r) begin
      if (sum_r < VMIN + t) begin
        flag_error(ST_OVF);
        sum_r = VMIN;
      end else begin
        sum_r = sum_r - t;
      end
    end else begin
      if (sum_r > VMAX - t) begin
        flag_error(ST_OVF);
        sum_r = VMAX;
      end else begin
        sum_r = sum_r + t;
      end
    end
    term_r = '0;
  endfunction

  // Consume one character; returns 1 with the answer on the last one.
  function automatic bit eval_char(logic [7:0] c, logic last, output answer_t ans);
    logic [31:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = {24'd0, c - CH_ZERO};
      if (acc_r > (ACC_MAX - d) / 10) begin
        acc_r = ACC_MAX;
        flag_error(ST_OVF);
      end else begin
        acc_r = acc_r * 10 + d;
      end
      open_r = 1'b1;
      have_digit_r = 1'b1;
      after_op_r = 1'b0;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV) begin
      if (!have_digit_r) flag_error(ST_POS);
      else if (after_op_r) flag_error(ST_TWO);
      end_literal();
      if (c == CH_MUL) begin
        top_r = TOP_MUL;
      end else if (c == CH_DIV) begin
        top_r = TOP_DIV;
      end else begin
        fold_into_sum();
        top_r = TOP_NONE;
        minus_r = (c == CH_MINUS);
      end
      after_op_r = 1'b1;
    end else if (c != CH_SPACE) begin
      flag_error(ST_BAD);
    end
    ans.value = '0;
    ans.status = ST_OK;
    if (!last) return 1'b0;
    if (!have_digit_r || after_op_r) flag_error(ST_POS);
    end_literal();
    fold_into_sum();
    ans.status = err_r;
    ans.value = (err_r == ST_BAD || err_r == ST_POS || err_r == ST_TWO) ? '0 : sum_r[VW-1:0];
    clear_eval();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Queue one expression string, last character marked.
  task automatic push_expr(string s);
    char_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.hold_for_drain = 1'b0;
      b.ch = s[i];
      b.last = (i == s.len() - 1);
      char_q.push_back(b);
    end
  endtask

  task automatic push_drain_pause();
    char_beat_t b;
    b.hold_for_drain = 1'b1;
    b.ch = '0;
    b.last = 1'b0;
    char_q.push_back(b);
  endtask

  function automatic string rand_literal();
    string s;
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
    s = "";
    for (int i = 0; i < n; i++) begin
      s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      if ($urandom_range(0, 19) == 0) s = {s, " "};
    end
    return s;
  endfunction

  function automatic string rand_expr();
    string s;
    string ops;
    int nterms;
    byte junk;
    ops = "+-*/";
    nterms = $urandom_range(1, 6);
    s = ($urandom_range(0, 9) == 0) ? " " : "";
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) begin
        s = {s, string'(ops[$urandom_range(0, 3)])};
        if ($urandom_range(0, 7) == 0) s = {s, " "};
      end
      s = {s, rand_literal()};
    end
    // A share of broken expressions: noise bytes and stray operators.
    case ($urandom_range(0, 11))
      0: begin
        junk = byte'($urandom_range(0, 255));
        s = {s, string'(junk)};
      end
      1: s = {string'(ops[$urandom_range(0, 3)]), s};
      2: s = {s, string'(ops[$urandom_range(0, 3)])};
      3: s = {s, string'(ops[$urandom_range(0, 3)]), string'(ops[$urandom_range(0, 3)]),
              rand_literal()};
      default: ;
    endcase
    return s;
  endfunction

  // Stimulus: directed expressions first, then random ones.
  initial begin
    int n;
    push_expr("0");
    push_expr("4294967295");
    push_expr("2147483647");
    push_expr("99999999999");
    push_expr("+5");
    push_expr("5+");
    push_expr("5+*3");
    push_expr("7/0");
    push_expr("1.5");
    push_expr(" ");
    push_expr("2*3+4/3-10");
    push_expr("1 2*3");
    push_expr("2147483647*2147483647*3");
    push_expr("0-2147483647*65536-2147483647*65536");
    push_expr("9/0*5+1");
    push_expr("7/2-1");
    push_drain_pause();
    n = 0;
    while (n < 2000) begin
      string s;
      s = rand_expr();
      push_expr(s);
      n += s.len();
      if ($urandom_range(0, 60) == 0) push_drain_pause();
    end
    stim_done = 1'b1;
  end

  // Driver: input changes at the falling edge.
  always @(negedge clk) begin
    logic       nv;
    logic [8:0] nd;
    nv = in_ch.valid;
    nd = in_ch.data;
    if (rst_n && (!in_ch.valid || in_took)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else begin
        if (char_q.size() > 0 && char_q[0].hold_for_drain && answer_q.size() == 0) begin
          void'(char_q.pop_front());
        end
        if (char_q.size() > 0 && !char_q[0].hold_for_drain) begin
          nv = 1'b1;
          nd = {char_q[0].last, char_q[0].ch};
          void'(char_q.pop_front());
          if ((cycles / 3000) % 3 != 0) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3: send_gap = $urandom_range(1, 3);
              4: send_gap = $urandom_range(10, 40);
              default: send_gap = 0;
            endcase
          end
        end
      end
    end
    in_ch.valid <= nv;
    in_ch.data <= nd;
  end

  // Receiver: random stalls plus one long hold-off so the input backs up.
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (cycles == 4000) begin
      recv_hold = 600;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      nr = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      nr = 1'b0;
    end else if ((cycles / 2500) % 3 != 1) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: recv_gap = $urandom_range(1, 3);
        4: recv_gap = $urandom_range(10, 40);
        default: recv_gap = 0;
      endcase
    end
    out_ch.ready <= rst_n ? nr : 1'b0;
  end

  // Monitor: predict on each input beat, check each output beat.
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    cycles++;
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (in_took) begin
      if (eval_char(in_ch.data[7:0], in_ch.data[8], want)) answer_q.push_back(want);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.value = out_ch.data[VW-1:0];
      got.status = out_ch.data[VW+2:VW];
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", {61'd0, got.status}, 64'd0);
      end else begin
        want = answer_q.pop_front();
        if (got.value !== want.value) report_mismatch("value", 64'(got.value), 64'(want.value));
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
      end
    end
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Start-up values and end of run.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    in_took = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    recv_hold = 0;
    clear_eval();
    wait (stim_done);
    wait (char_q.size() == 0 && !in_ch.valid);
    wait (answer_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ifx_pkg.sv
rtl/ifx_if.sv
rtl/ifx_front.sv
rtl/ifx_back.sv
rtl/infix_four_op_evaluator.sv
tb/infix_four_op_evaluator_test.sv
